// ----- src/skf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// skf_pkg: shared types and constants of the scalar Kalman filter
// Holds the sequencer state type, the register map and the fixed widths of
// the covariance and noise registers.
// ---------------------------------------------------------------------------
package skf_pkg;

	// Covariance and noise registers are 24 bits wide, unsigned.
	localparam int unsigned COV_W = 24;
	localparam logic [COV_W-1:0] COV_MAX = {COV_W{1'b1}};

	// Estimate and result width.
	localparam int unsigned EST_W = 32;

	// Reset values of the noise registers.
	localparam logic [COV_W-1:0] Q_NOISE_RESET = 24'd655;
	localparam logic [COV_W-1:0] R_NOISE_RESET = 24'd6554;

	// Register map: index taken from paddr[2].
	localparam int unsigned PADDR_W = 3;
	localparam logic REG_Q_NOISE = 1'b0;
	localparam logic REG_R_NOISE = 1'b1;

	// Sequencer states, one-hot.
	typedef enum logic [8:0] {
		ST_IDLE = 9'b000000001,
		ST_LOAD = 9'b000000010,
		ST_PRED = 9'b000000100,
		ST_DEN  = 9'b000001000,
		ST_DIV  = 9'b000010000,
		ST_GAIN = 9'b000100000,
		ST_MUL  = 9'b001000000,
		ST_RND  = 9'b010000000,
		ST_DONE = 9'b100000000
	} skf_state_t;

endpackage
`default_nettype wire

// ----- src/scalar_kalman_filter.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// scalar_kalman_filter: one-dimensional constant-model Kalman filter
// Smooths a stream of signed samples with a bit-serial divider for the gain
// and two bit-serial multipliers for the estimate and covariance updates.
// ---------------------------------------------------------------------------
// Each accepted sample produces one filtered estimate, signed with FRAC_BITS
// fractional bits. A sample flagged as first reloads the estimate with the
// sample and the covariance with 0.02 before the update runs. A sample
// passes through load, prediction, denominator setup, the one-bit-per-cycle
// restoring divider that forms the gain, gain setup, the shift-add
// multipliers, rounding and write-back. Samples are processed one at a time;
// a new sample is accepted while the previous result still waits in the
// output register, and the write-back of that sample waits until the output
// register is free. The noise registers q_noise (byte address 0) and r_noise
// (byte address 4) are to be written over the APB port only while the filter
// is idle; the filter itself does not enforce this.
module scalar_kalman_filter
	import skf_pkg::*;
#(
	parameter int unsigned SAMPLE_BITS = 16,
	parameter int unsigned FRAC_BITS   = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// Sample channel.
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic signed [SAMPLE_BITS-1:0] sample,
	input  wire logic                          first,
	// Result channel.
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic signed [EST_W-1:0]            filtered,
	// Configuration port.
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [PADDR_W-1:0]            paddr,
	input  wire logic [31:0]                   pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready
);

	// Gain width: FRAC_BITS fraction plus the integer bit for 1.0.
	localparam int unsigned GW  = FRAC_BITS + 1;
	// Magnitude of the innovation: up to 2^32 - 1.
	localparam int unsigned MW  = EST_W + 1;
	localparam int unsigned PW1 = MW + GW;
	localparam int unsigned PW2 = COV_W + GW;
	localparam int unsigned DW  = COV_W + 1;
	localparam int unsigned CW  = $clog2(GW + 1);
	localparam int unsigned XW  = SAMPLE_BITS + FRAC_BITS + EST_W;
	localparam int unsigned SW  = EST_W + 4;

	localparam logic [COV_W-1:0] COV_START =
		COV_W'(((64'd2 << FRAC_BITS) + 64'd50) / 64'd100);
	localparam logic [GW-1:0] ONE_FIX = {1'b1, {FRAC_BITS{1'b0}}};
	localparam logic [PW1-1:0] HALF1 = PW1'(64'd1 << (FRAC_BITS - 1));
	localparam logic [PW2-1:0] HALF2 = PW2'(64'd1 << (FRAC_BITS - 1));
	localparam logic signed [XW-1:0] EST_MAX_X = XW'(64'sh7FFFFFFF);
	localparam logic signed [XW-1:0] EST_MIN_X = XW'(-64'sd2147483648);
	localparam logic signed [SW-1:0] EST_MAX_S = SW'(64'sh7FFFFFFF);
	localparam logic signed [SW-1:0] EST_MIN_S = SW'(-64'sd2147483648);

	skf_state_t state_q;

	// Configuration registers.
	logic [COV_W-1:0] q_noise_q;
	logic [COV_W-1:0] r_noise_q;

	// Filter state.
	logic signed [EST_W-1:0] est_q;
	logic [COV_W-1:0]        cov_q;

	// Working registers.
	logic signed [SAMPLE_BITS-1:0] sample_q;
	logic                          first_q;
	logic signed [EST_W-1:0]       meas_q;
	logic [COV_W-1:0]              pm_q;
	logic [DW-1:0]                 den_q;
	logic [DW-1:0]                 rem_q;
	logic [FRAC_BITS-1:0]          quo_q;
	logic                          qtop_q;
	logic                          dz_q;
	logic [MW-1:0]                 mag_q;
	logic                          neg_q;
	logic [PW1-1:0]                p1_q;
	logic [PW2-1:0]                p2_q;
	logic [MW:0]                   rnd_q;
	logic [COV_W-1:0]              np_q;
	logic [CW-1:0]                 cnt_q;
	logic                          out_valid_q;
	logic signed [EST_W-1:0]       filtered_q;

	logic cfg_wr;
	logic in_acc;
	logic out_free;

	// Measurement in fixed point, saturated to 32 bits.
	logic signed [XW-1:0]    meas_x;
	logic signed [EST_W-1:0] meas_sat;

	// Prediction and innovation.
	logic [DW-1:0]          pm_sum;
	logic [COV_W-1:0]       pm_sat;
	logic signed [EST_W:0]  diff;

	// Divider step.
	logic [DW:0] rem2;
	logic        rem_ge;

	// Gain.
	logic [GW-1:0] gain;

	// Multiplier steps.
	logic [MW:0]    s1;
	logic [COV_W:0] s2;

	// Rounding and write-back.
	logic [PW1-1:0]          r1_sum;
	logic [PW2-1:0]          r2_sum;
	logic [COV_W:0]          np_wide;
	logic signed [SW-1:0]    est_sum;
	logic signed [EST_W-1:0] est_new;

	assign cfg_wr   = psel && penable && pwrite && pready;
	assign in_ready = (state_q == ST_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign filtered  = filtered_q;
	assign pready    = 1'b1;

	// Register readback.
	always_comb begin
		case (paddr[2])
			REG_Q_NOISE: prdata = {8'd0, q_noise_q};
			REG_R_NOISE: prdata = {8'd0, r_noise_q};
			default:     prdata = '0;
		endcase
	end

	// Scale the sample to fixed point and clamp to the estimate range.
	always_comb begin
		meas_x = XW'(sample_q) <<< FRAC_BITS;
		if (meas_x > EST_MAX_X) begin
			meas_sat = EST_MAX_S[EST_W-1:0];
		end else if (meas_x < EST_MIN_X) begin
			meas_sat = EST_MIN_S[EST_W-1:0];
		end else begin
			meas_sat = meas_x[EST_W-1:0];
		end
	end

	// Predicted covariance, saturated, and the innovation.
	always_comb begin
		pm_sum = {1'b0, cov_q} + {1'b0, q_noise_q};
		pm_sat = pm_sum[COV_W] ? COV_MAX : pm_sum[COV_W-1:0];
		diff   = (EST_W + 1)'(meas_q) - (EST_W + 1)'(est_q);
	end

	// One restoring division step per cycle.
	always_comb begin
		rem2   = {rem_q, 1'b0};
		rem_ge = (rem2 >= {1'b0, den_q});
	end

	// The gain is exactly 1.0 when the denominator is zero.
	assign gain = dz_q ? ONE_FIX : {qtop_q, quo_q};

	// One shift-add step of each multiplier per cycle.
	always_comb begin
		s1 = {1'b0, p1_q[PW1-1:GW]} + (p1_q[0] ? {1'b0, mag_q} : '0);
		s2 = {1'b0, p2_q[PW2-1:GW]} + (p2_q[0] ? {1'b0, pm_q} : '0);
	end

	// Round both products to nearest.
	always_comb begin
		r1_sum  = p1_q + HALF1;
		r2_sum  = p2_q + HALF2;
		np_wide = r2_sum[PW2-1:FRAC_BITS];
	end

	// Apply the correction to the estimate with saturation.
	always_comb begin
		if (neg_q) begin
			est_sum = SW'(est_q) - SW'({1'b0, rnd_q});
		end else begin
			est_sum = SW'(est_q) + SW'({1'b0, rnd_q});
		end
		if (est_sum > EST_MAX_S) begin
			est_new = EST_MAX_S[EST_W-1:0];
		end else if (est_sum < EST_MIN_S) begin
			est_new = EST_MIN_S[EST_W-1:0];
		end else begin
			est_new = est_sum[EST_W-1:0];
		end
	end

	// Sequencer, configuration registers, filter state and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			q_noise_q   <= Q_NOISE_RESET;
			r_noise_q   <= R_NOISE_RESET;
			est_q       <= '0;
			cov_q       <= COV_START;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			if (cfg_wr) begin
				case (paddr[2])
					REG_Q_NOISE: q_noise_q <= pwdata[COV_W-1:0];
					REG_R_NOISE: r_noise_q <= pwdata[COV_W-1:0];
					default: ;
				endcase
			end

			// The write-back below refills the register in the cycle it is taken.
			if (out_valid_q && out_ready && (state_q != ST_DONE)) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					// A first sample restarts the sequence.
					if (first_q) begin
						est_q <= meas_sat;
						cov_q <= COV_START;
					end
					state_q <= ST_PRED;
				end
				ST_PRED: begin
					state_q <= ST_DEN;
				end
				ST_DEN: begin
					cnt_q   <= CW'(FRAC_BITS - 1);
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (cnt_q == '0) begin
						state_q <= ST_GAIN;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				ST_GAIN: begin
					cnt_q   <= CW'(GW - 1);
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					if (cnt_q == '0) begin
						state_q <= ST_RND;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				ST_RND: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					// Commit once the output register can take the word.
					if (out_free) begin
						est_q       <= est_new;
						cov_q       <= np_q;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					sample_q <= sample;
					first_q  <= first;
				end
			end
			ST_LOAD: begin
				meas_q <= meas_sat;
			end
			ST_PRED: begin
				pm_q  <= pm_sat;
				neg_q <= diff[EST_W];
				mag_q <= diff[EST_W] ? MW'(-diff) : MW'(diff);
			end
			ST_DEN: begin
				// The integer bit of the quotient is set only when r_noise is zero.
				den_q <= {1'b0, pm_q} + {1'b0, r_noise_q};
				dz_q  <= (pm_q == '0) && (r_noise_q == '0);
				quo_q <= '0;
				if (r_noise_q == '0) begin
					qtop_q <= (pm_q != '0);
					rem_q  <= '0;
				end else begin
					qtop_q <= 1'b0;
					rem_q  <= {1'b0, pm_q};
				end
			end
			ST_DIV: begin
				rem_q <= rem_ge ? DW'(rem2 - {1'b0, den_q}) : rem2[DW-1:0];
				quo_q <= {quo_q[FRAC_BITS-2:0], rem_ge};
			end
			ST_GAIN: begin
				p1_q <= {{MW{1'b0}}, gain};
				p2_q <= {{COV_W{1'b0}}, GW'(ONE_FIX - gain)};
			end
			ST_MUL: begin
				p1_q <= {s1, p1_q[GW-1:1]};
				p2_q <= {s2, p2_q[GW-1:1]};
			end
			ST_RND: begin
				rnd_q <= r1_sum[PW1-1:FRAC_BITS];
				np_q  <= np_wide[COV_W] ? COV_MAX : np_wide[COV_W-1:0];
			end
			ST_DONE: begin
				if (out_free) begin
					filtered_q <= est_new;
				end
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

// ----- src/skf_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// skf_checker: port-level checks of the scalar Kalman filter
// Watches the handshakes and the register port of the top level.
// ---------------------------------------------------------------------------
module skf_checker
	import skf_pkg::*;
(
	input wire logic                    clk,
	input wire logic                    arst_n,
	input wire logic                    in_valid,
	input wire logic                    in_ready,
	input wire logic                    out_valid,
	input wire logic                    out_ready,
	input wire logic signed [EST_W-1:0] filtered,
	input wire logic                    psel,
	input wire logic                    penable,
	input wire logic                    pwrite,
	input wire logic [PADDR_W-1:0]      paddr,
	input wire logic [31:0]             pwdata,
	input wire logic [31:0]             prdata,
	input wire logic                    pready
);

	// A result word holds until it is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(filtered))
	else $error("result word changed or dropped while stalled");

	// The filter works on one sample at a time.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
	else $error("sample accepted while a sample is in progress");

	// A register write reads back its low 24 bits at the same address.
	assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && pready |=>
			(paddr[2] != $past(paddr[2])) ||
			(prdata == {8'd0, $past(pwdata[COV_W-1:0])}))
	else $error("register readback differs from written word");

	// Upper readback bits are always zero and the port never waits.
	assert property (@(posedge clk) disable iff (!arst_n)
		pready && (prdata[31:COV_W] == '0))
	else $error("register port stalled or readback has stray upper bits");

endmodule

bind scalar_kalman_filter skf_checker u_skf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.filtered  (filtered),
	.psel      (psel),
	.penable   (penable),
	.pwrite    (pwrite),
	.paddr     (paddr),
	.pwdata    (pwdata),
	.prdata    (prdata),
	.pready    (pready)
);
`default_nettype wire
